// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_W        = 32;
    localparam int DET_W          = 64;
    localparam int N_ENT          = 9;

    // Operand indexes of each adjugate entry: a[0]*a[1] - a[2]*a[3].
    localparam int unsigned M2_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // Adjugate entries used by the row 0 expansion of the determinant.
    localparam int unsigned DET_IDX [3] = '{0, 3, 6};

    typedef struct packed {
        logic [FIELD_W-1:0] in_r0_c0;
        logic [FIELD_W-1:0] in_r0_c1;
        logic [FIELD_W-1:0] in_r0_c2;
        logic [FIELD_W-1:0] in_r1_c0;
        logic [FIELD_W-1:0] in_r1_c1;
        logic [FIELD_W-1:0] in_r1_c2;
        logic [FIELD_W-1:0] in_r2_c0;
        logic [FIELD_W-1:0] in_r2_c1;
        logic [FIELD_W-1:0] in_r2_c2;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] inv_r0_c0;
        logic [FIELD_W-1:0] inv_r0_c1;
        logic [FIELD_W-1:0] inv_r0_c2;
        logic [FIELD_W-1:0] inv_r1_c0;
        logic [FIELD_W-1:0] inv_r1_c1;
        logic [FIELD_W-1:0] inv_r1_c2;
        logic [FIELD_W-1:0] inv_r2_c0;
        logic [FIELD_W-1:0] inv_r2_c1;
        logic [FIELD_W-1:0] inv_r2_c2;
        logic [DET_W-1:0]   det_value;
        logic               singular;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/m3i_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_front #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
    input  wire                             i_clk,
    input  wire  [5:0]                      i_en,
    input  m3i_pkg::t_in                    i_data,
    output logic signed [2*DATA_WIDTH:0]    o_adj [m3i_pkg::N_ENT],
    output logic signed [3*DATA_WIDTH:0]    o_det
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int AW  = 2 * DW + 1;
    localparam int DTW = 3 * DW + 1;
    localparam int NE  = m3i_pkg::N_ENT;

    logic [m3i_pkg::FIELD_W-1:0] w [NE];

    logic signed [DW-1:0]   r_a   [NE];
    logic signed [DW-1:0]   r_b1  [3];
    logic signed [DW-1:0]   r_b2  [3];
    logic signed [PW-1:0]   r_p1  [NE];
    logic signed [PW-1:0]   r_p2  [NE];
    logic signed [AW-1:0]   r_adj2 [NE];
    logic signed [AW-1:0]   r_adj3 [NE];
    logic signed [AW-1:0]   r_adj4 [NE];
    logic signed [AW-1:0]   r_adj5 [NE];
    logic signed [2*DW:0]   r_mh  [3];
    logic signed [2*DW:0]   r_ml  [3];
    logic signed [DTW-1:0]  r_t4  [3];
    logic signed [DTW-1:0]  r_det5;

    assign w[0] = i_data.in_r0_c0;
    assign w[1] = i_data.in_r0_c1;
    assign w[2] = i_data.in_r0_c2;
    assign w[3] = i_data.in_r1_c0;
    assign w[4] = i_data.in_r1_c1;
    assign w[5] = i_data.in_r1_c2;
    assign w[6] = i_data.in_r2_c0;
    assign w[7] = i_data.in_r2_c1;
    assign w[8] = i_data.in_r2_c2;

    for (genvar k = 0; k < NE; k++) begin : g_ent
        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_a[k] <= w[k][DW-1:0];
            end
            if (i_en[1]) begin
                r_p1[k] <= r_a[m3i_pkg::M2_IDX[k][0]] * r_a[m3i_pkg::M2_IDX[k][1]];
                r_p2[k] <= r_a[m3i_pkg::M2_IDX[k][2]] * r_a[m3i_pkg::M2_IDX[k][3]];
            end
            if (i_en[2]) begin
                r_adj2[k] <= {r_p1[k][PW-1], r_p1[k]} - {r_p2[k][PW-1], r_p2[k]};
            end
            if (i_en[3]) begin
                r_adj3[k] <= r_adj2[k];
            end
            if (i_en[4]) begin
                r_adj4[k] <= r_adj3[k];
            end
            if (i_en[5]) begin
                r_adj5[k] <= r_adj4[k];
            end
        end
        assign o_adj[k] = r_adj5[k];
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        logic signed [DW:0] hi;
        logic signed [DW:0] lo;

        assign hi = r_adj2[m3i_pkg::DET_IDX[j]][AW-1:DW];
        assign lo = {1'b0, r_adj2[m3i_pkg::DET_IDX[j]][DW-1:0]};

        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_b1[j] <= r_a[j];
            end
            if (i_en[2]) begin
                r_b2[j] <= r_b1[j];
            end
            if (i_en[3]) begin
                r_mh[j] <= r_b2[j] * hi;
                r_ml[j] <= r_b2[j] * lo;
            end
            if (i_en[4]) begin
                r_t4[j] <= (DTW'(r_mh[j]) <<< DW) + DTW'(r_ml[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_det5 <= r_t4[0] + r_t4[1] + r_t4[2];
        end
    end

    assign o_det = r_det5;

endmodule

`default_nettype wire

// ===== rtl/m3i_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_div_lane #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire  [DATA_WIDTH+1:0]         i_en,
    input  wire  signed [2*DATA_WIDTH:0]  i_adj,
    input  wire  signed [3*DATA_WIDTH:0]  i_det,
    output logic [DATA_WIDTH:0]           o_q,
    output logic                          o_neg,
    output logic                          o_ovf
);

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = 2 * DW + 1;
    localparam int DTW = 3 * DW + 1;
    localparam int DNW = DTW + 1;
    localparam int QW  = DW + 1;
    localparam int NA  = 2 * DW + 2 * FRAC_BITS + 1;
    localparam int NW  = ((NA > 3 * DW) ? NA : 3 * DW) + 1;

    logic [AW-1:0]  adj_abs;
    logic [DTW-1:0] dmag;
    logic [NW-1:0]  num;
    logic [DNW-1:0] den;

    logic [NW-1:0]  r_rem [QW+1];
    logic [DNW-1:0] r_den [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic           r_neg [QW+1];
    logic           r_ovf [QW+1];

    assign adj_abs = i_adj[AW-1] ? AW'(-i_adj) : AW'(i_adj);
    assign dmag    = i_det[DTW-1] ? DTW'(-i_det) : DTW'(i_det);
    assign num     = (NW'(adj_abs) << (2 * FRAC_BITS + 1)) + NW'(dmag);
    assign den     = {dmag, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= num;
            r_den[0] <= den;
            r_q[0]   <= '0;
            r_neg[0] <= i_adj[AW-1] ^ i_det[DTW-1];
            r_ovf[0] <= (num >> QW) >= NW'(den);
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        localparam int B = QW - s;
        logic take;

        assign take = (r_rem[s-1] >> B) >= NW'(r_den[s-1]);

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= take ? r_rem[s-1] - (NW'(r_den[s-1]) << B) : r_rem[s-1];
                r_q[s]   <= r_q[s-1] | (QW'(take) << B);
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_neg = r_neg[QW];
    assign o_ovf = r_ovf[QW];

endmodule

`default_nettype wire

// ===== rtl/m3i_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_merge #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire  [DATA_WIDTH+2:0]         i_en,
    input  wire  signed [3*DATA_WIDTH:0]  i_det,
    input  wire  [DATA_WIDTH:0]           i_q   [m3i_pkg::N_ENT],
    input  wire                           i_neg [m3i_pkg::N_ENT],
    input  wire                           i_ovf [m3i_pkg::N_ENT],
    output m3i_pkg::t_out                 o_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int DTW = 3 * DW + 1;
    localparam int QW  = DW + 1;
    localparam int NE  = m3i_pkg::N_ENT;
    localparam int FW  = m3i_pkg::FIELD_W;
    localparam int SH  = 3 * FRAC_BITS - 32;
    localparam int XW  = (SH > 0) ? DTW + 1 : DTW - SH;
    localparam int XE  = (XW > 64) ? XW : 65;
    localparam logic [QW-1:0] LIM = QW'(1) << (DW - 1);

    logic signed [XW-1:0] xr;
    logic signed [XE-1:0] xe;
    logic                 fits;
    logic [63:0]          d64;

    logic [63:0]     r_d64 [QW+1];
    logic            r_sng [QW+1];
    logic [FW-1:0]   val   [NE];
    m3i_pkg::t_out   r_out;

    if (SH > 0) begin : g_rshift
        logic signed [XW-1:0] xs;
        assign xs = XW'(i_det) + (XW'(1) << (SH - 1));
        assign xr = xs >>> SH;
    end else begin : g_lshift
        assign xr = XW'(i_det) <<< (-SH);
    end

    assign xe   = XE'(xr);
    assign fits = (&xe[XE-1:63]) | ~(|xe[XE-1:63]);
    assign d64  = fits ? xe[63:0] : (xe[XE-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d64[0] <= d64;
            r_sng[0] <= (i_det == '0);
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_d64[s] <= r_d64[s-1];
                r_sng[s] <= r_sng[s-1];
            end
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_sat
        logic signed [DW-1:0] v;

        always_comb begin
            if (i_neg[k]) begin
                if (i_ovf[k] || (i_q[k] > LIM)) begin
                    v = DW'(LIM);
                end else begin
                    v = -DW'(i_q[k]);
                end
            end else begin
                if (i_ovf[k] || (i_q[k] >= LIM)) begin
                    v = DW'(LIM - QW'(1));
                end else begin
                    v = DW'(i_q[k]);
                end
            end
        end

        assign val[k] = r_sng[QW] ? '0 : FW'(v);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+1]) begin
            r_out.inv_r0_c0 <= val[0];
            r_out.inv_r0_c1 <= val[1];
            r_out.inv_r0_c2 <= val[2];
            r_out.inv_r1_c0 <= val[3];
            r_out.inv_r1_c1 <= val[4];
            r_out.inv_r1_c2 <= val[5];
            r_out.inv_r2_c0 <= val[6];
            r_out.inv_r2_c1 <= val[7];
            r_out.inv_r2_c2 <= val[8];
            r_out.det_value <= r_sng[QW] ? '0 : r_d64[QW];
            r_out.singular  <= r_sng[QW];
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

// ===== rtl/matrix3_inverse.sv =====
// Channel | Valid        | Ready        | Payload
// input   | i_in_valid   | o_in_ready   | i_in_data  (m3i_pkg::t_in)
// output  | o_out_valid  | i_out_ready  | o_out_data (m3i_pkg::t_out)
//
// One matrix is taken per cycle unless every stage is full and the output is stalled.
// The depth is set by the six front stages, the divider operand register and one quotient
// bit per divider stage in each of the nine lanes, and the output register.
// Every stage holds its item while the stage after it is full and cannot move on, so bubbles close up.
// Reset clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  m3i_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output m3i_pkg::t_out  o_out_data
);

    localparam int DW   = DATA_WIDTH;
    localparam int QW   = DW + 1;
    localparam int LAST = 7 + QW;
    localparam int NS   = LAST + 1;
    localparam int NE   = m3i_pkg::N_ENT;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic signed [2*DW:0] adj [NE];
    logic signed [3*DW:0] det;
    logic [QW-1:0]        q   [NE];
    logic                 neg [NE];
    logic                 ovf [NE];

    assign en[LAST] = ~r_vld[LAST] | i_out_ready;
    for (genvar k = 0; k < LAST; k++) begin : g_en
        assign en[k] = ~r_vld[k] | en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    m3i_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_clk  (i_clk),
        .i_en   (en[5:0]),
        .i_data (i_in_data),
        .o_adj  (adj),
        .o_det  (det)
    );

    for (genvar k = 0; k < NE; k++) begin : g_lane
        m3i_div_lane #(
            .DATA_WIDTH(DATA_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en[6+QW:6]),
            .i_adj (adj[k]),
            .i_det (det),
            .o_q   (q[k]),
            .o_neg (neg[k]),
            .o_ovf (ovf[k])
        );
    end

    m3i_merge #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (en[LAST:6]),
        .i_det  (det),
        .i_q    (q),
        .i_neg  (neg),
        .i_ovf  (ovf),
        .o_data (o_out_data)
    );

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[LAST];

endmodule

`default_nettype wire

// ===== rtl/m3i_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            o_in_ready,
    input wire            o_out_valid,
    input wire            i_out_ready,
    input m3i_pkg::t_out  o_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.singular) |->
            (o_out_data.det_value == '0) && (o_out_data.inv_r0_c0 == '0)
            && (o_out_data.inv_r0_c1 == '0) && (o_out_data.inv_r0_c2 == '0)
            && (o_out_data.inv_r1_c0 == '0) && (o_out_data.inv_r1_c1 == '0)
            && (o_out_data.inv_r1_c2 == '0) && (o_out_data.inv_r2_c0 == '0)
            && (o_out_data.inv_r2_c1 == '0) && (o_out_data.inv_r2_c2 == '0))
        else $error("singular result carries nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
